FILE: rtl/core/ibuf_pkg.sv
// Package for the indexed sequence buffer: sizes, request, status and cell command codes,
// and the command struct that the controller broadcasts to the row of cells.
// No dependencies.
package ibuf_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;
	localparam int REQ_W    = 3;
	localparam int POS_W    = 5;
	localparam int OCC_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND    = 3'd0,
		REQ_PREPEND   = 3'd1,
		REQ_INSERT    = 3'd2,
		REQ_DELETE    = 3'd3,
		REQ_DEL_FIRST = 3'd4,
		REQ_DEL_LAST  = 3'd5,
		REQ_CLEAR     = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [CMP_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} cell_cmd_t;

endpackage

FILE: rtl/core/ibuf_cell.sv
// One storage cell of the sequence buffer row.
// Depends on ibuf_pkg for the command struct and widths.
module ibuf_cell (
	input  logic                      clk,
	input  ibuf_pkg::cell_cmd_t       cmd,
	input  logic [ibuf_pkg::IDX_W-1:0]  idx,
	input  logic [ibuf_pkg::WORD_W-1:0] below,
	input  logic [ibuf_pkg::WORD_W-1:0] above,
	output logic [ibuf_pkg::WORD_W-1:0] data
);
	import ibuf_pkg::*;

	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] data_d;
	logic [CMP_W-1:0]  idx_x;

	assign idx_x = CMP_W'(idx);

	// An insert moves every cell above the gap up by one; a delete pulls them down.
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			OP_INS: begin
				if (idx_x > cmd.pos) begin
					data_d = below;
				end else if (idx_x == cmd.pos) begin
					data_d = cmd.word;
				end
			end
			OP_DEL: begin
				if (idx_x >= cmd.pos) begin
					data_d = above;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

FILE: rtl/core/ibuf_ctrl.sv
// Request decoder and occupancy counter of the sequence buffer; it drives the cell command.
// Depends on ibuf_pkg for codes, widths and the command struct.
module ibuf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [ibuf_pkg::REQ_W-1:0]  req_type,
	input  logic [ibuf_pkg::WORD_W-1:0] word,
	input  logic [ibuf_pkg::POS_W-1:0]  position,
	output ibuf_pkg::cell_cmd_t         cmd,
	output logic [ibuf_pkg::CNT_W-1:0]  count,
	output ibuf_pkg::status_t           status,
	output logic                        done
);
	import ibuf_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	status_t          status_q;
	status_t          status_d;
	logic             done_q;
	logic             full;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	cell_op_t         op_d;
	logic [CMP_W-1:0] at_d;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);

	always_comb begin
		op_d     = OP_HOLD;
		at_d     = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (req_t'(req_type))
			REQ_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = OP_INS;
					at_d    = cnt_x;
					count_d = count_q + 1'b1;
				end
			end
			REQ_PREPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = OP_INS;
					count_d = count_q + 1'b1;
				end
			end
			REQ_INSERT: begin
				// The index test comes before the full test.
				if (pos_x > cnt_x) begin
					status_d = ST_BAD_INDEX;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = OP_INS;
					at_d    = pos_x;
					count_d = count_q + 1'b1;
				end
			end
			REQ_DELETE: begin
				if (pos_x >= cnt_x) begin
					status_d = ST_BAD_INDEX;
				end else begin
					op_d    = OP_DEL;
					at_d    = pos_x;
					count_d = count_q - 1'b1;
				end
			end
			REQ_DEL_FIRST: begin
				if (count_q == '0) begin
					status_d = ST_UNDERFLOW;
				end else begin
					op_d    = OP_DEL;
					count_d = count_q - 1'b1;
				end
			end
			REQ_DEL_LAST: begin
				// Removing the last entry on an empty store is silently ignored.
				if (count_q != '0) begin
					op_d    = OP_DEL;
					at_d    = cnt_x - 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			REQ_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		cmd.op   = accept ? op_d : OP_HOLD;
		cmd.pos  = at_d;
		cmd.word = word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	assign count  = count_q;
	assign status = status_q;
	assign done   = done_q;

endmodule

FILE: rtl/core/indexed_sequence_buffer_core.sv
// Top level of the indexed sequence buffer: a controller and a row of shifting cells.
// Depends on ibuf_pkg, ibuf_ctrl and ibuf_cell.
//
//   Channel   Handshake          Payload
//   request   start / busy       req_type, value, position
//   result    done (strobe)      status, occupancy, head_value
//
// A request beat is taken at any rising edge where start is high and busy is low.
// Every cell updates in that same edge, so busy stays low and one request can be
// taken every cycle; the row of cells shifts in parallel, so an insert or delete completes
// in that edge whatever the position. The result beat shows on the strobe in the cycle
// after the request and is present for exactly one cycle: the receiver cannot stall it.
// Reset clears the occupancy and the strobe; the cell contents are not reset.
module indexed_sequence_buffer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ibuf_pkg::REQ_W-1:0]         req_type,
	input  logic signed [ibuf_pkg::WORD_W-1:0] value,
	input  logic [ibuf_pkg::POS_W-1:0]         position,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [ibuf_pkg::OCC_W-1:0]         occupancy,
	output logic signed [ibuf_pkg::WORD_W-1:0] head_value
);
	import ibuf_pkg::*;

	logic              accept;
	cell_cmd_t         cmd;
	logic [CNT_W-1:0]  count;
	status_t           status_w;
	logic [WORD_W-1:0] cell_data [CAPACITY];

	// Every request completes in the edge that accepts it, so the block is never busy.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	ibuf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.word     (value),
		.position (position),
		.cmd      (cmd),
		.count    (count),
		.status   (status_w),
		.done     (done)
	);

	// Cell i takes from cell i-1 on an insert and from cell i+1 on a delete. The ends of
	// the row are fed with zero; those words only land in cells beyond the occupancy.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] below;
		logic [WORD_W-1:0] above;

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_mid_lo
			assign below = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign above = '0;
		end else begin : g_mid_hi
			assign above = cell_data[i+1];
		end

		ibuf_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (IDX_W'(i)),
			.below (below),
			.above (above),
			.data  (cell_data[i])
		);
	end

	// The result reads registered state only: the count and the first cell, as they
	// stand after the request. An empty store reports all ones as its head.
	assign status     = status_w;
	assign occupancy  = OCC_W'(count);
	assign head_value = (count == '0) ? '1 : cell_data[0];

endmodule

FILE: rtl/core/ibuf_chk.sv
// Port-level checker for the indexed sequence buffer, bound to the top level.
// Depends on ibuf_pkg for status codes and capacity.
module ibuf_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [1:0]                         status,
	input logic [ibuf_pkg::OCC_W-1:0]         occupancy,
	input logic signed [ibuf_pkg::WORD_W-1:0] head_value
);
	import ibuf_pkg::*;

	// Each accepted request beat gives exactly one result beat on the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request beat without a result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result beat without a request beat");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == OCC_W'(CAPACITY)))
		else $error("full status while the store is not full");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(done && occupancy == '0) |-> (head_value == -32'sd1))
		else $error("empty store does not report all ones as head");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNDERFLOW) |-> (occupancy == '0))
		else $error("underflow reported on a store that holds entries");

endmodule

bind indexed_sequence_buffer_core ibuf_chk u_ibuf_chk (.*);
